### src/imu_sample_time_interpolator_defines.svh
// ---------------------------------------------------------------------------
// IMU sample time interpolator: assertion macros
// Shared property forms for the checker.
// ---------------------------------------------------------------------------
`ifndef IMU_SAMPLE_TIME_INTERPOLATOR_DEFINES_SVH
`define IMU_SAMPLE_TIME_INTERPOLATOR_DEFINES_SVH

// antecedent and consequent in the same cycle
`define ISTI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isti assertion failed");

// consequent in the cycle after the antecedent
`define ISTI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isti assertion failed");

`endif

### src/isti_pkg.sv
// ---------------------------------------------------------------------------
// IMU sample time interpolator package
// Widths, codes, sample record, controller states and command/status groups.
// ---------------------------------------------------------------------------
package isti_pkg;

   localparam int FIFO_DEPTH_DEF = 16;
   localparam int TIME_W         = 48;
   localparam int MOT_W          = 32;
   localparam int QUAT_W         = 16;
   localparam int GAP_W          = 24;
   localparam int WBITS          = 16;

   localparam logic [GAP_W-1:0] GAP_RESET = 24'd200000;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EARLY = 2'd1;
   localparam logic [1:0] STATUS_FEW   = 2'd2;

   localparam logic MODE_PUSH  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef logic signed [MOT_W-1:0]  mot_type;
   typedef logic signed [QUAT_W-1:0] quat_comp_type;

   typedef struct packed {
      logic [TIME_W-1:0]   time_us;
      mot_type [2:0]       accel;
      mot_type [2:0]       gyro;
      quat_comp_type [3:0] quat;
   } isti_rec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD0,
      ST_RD1,
      ST_CMP,
      ST_WEIGHT,
      ST_WDIV,
      ST_BLEND,
      ST_SQUARE,
      ST_SQRT,
      ST_NORM,
      ST_NWAIT,
      ST_OUT
   } isti_state_type;

   typedef struct packed {
      logic       push;
      logic       query_load;
      logic       rd_front;
      logic       rd_second;
      logic       cap_front;
      logic       cap_second;
      logic       drop;
      logic       weight;
      logic       weight_store;
      logic       blend;
      logic       square;
      logic       sqrt;
      logic       norm_start;
      logic       norm_store;
      logic       result;
      logic [1:0] status;
   } isti_cmd_type;

   typedef struct packed {
      logic few;
      logic early;
      logic later;
      logic gap;
      logic div_busy;
      logic blend_last;
      logic square_last;
      logic sqrt_last;
      logic norm_zero;
      logic norm_last;
      logic out_busy;
   } isti_stat_type;

endpackage

### src/imu_sample_time_interpolator.sv
// ---------------------------------------------------------------------------
// IMU sample time interpolator
// Ring buffer of IMU samples; queries prune it and blend the bracketing pair.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  req_     | in        | req_valid/req_ready | mode, time, accel, gyro, quat
//  rsp_     | out       | rsp_valid/rsp_ready | status, query time, blended sample
//  csr_     | in        | csr_wr_en           | max_gap_us
//
//  A push is stored in the cycle it is accepted. A query runs the prune passes,
//  then the weight division, the blend and the squares on the
//  one shared multiplier, the root and the serial divider
//  normalising the quaternion.
//  Synchronous reset empties the ring and restores max_gap_us to 200000.
//  A stalled result holds in the output register; the next push is still taken.
// ---------------------------------------------------------------------------
module imu_sample_time_interpolator import isti_pkg::*; #(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic [TIME_W-1:0]        req_time_us,
   input  logic signed [MOT_W-1:0]  req_accel_x,
   input  logic signed [MOT_W-1:0]  req_accel_y,
   input  logic signed [MOT_W-1:0]  req_accel_z,
   input  logic signed [MOT_W-1:0]  req_gyro_x,
   input  logic signed [MOT_W-1:0]  req_gyro_y,
   input  logic signed [MOT_W-1:0]  req_gyro_z,
   input  logic signed [QUAT_W-1:0] req_quat_x,
   input  logic signed [QUAT_W-1:0] req_quat_y,
   input  logic signed [QUAT_W-1:0] req_quat_z,
   input  logic signed [QUAT_W-1:0] req_quat_w,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [TIME_W-1:0]        rsp_out_time_us,
   output logic signed [MOT_W-1:0]  rsp_out_accel_x,
   output logic signed [MOT_W-1:0]  rsp_out_accel_y,
   output logic signed [MOT_W-1:0]  rsp_out_accel_z,
   output logic signed [MOT_W-1:0]  rsp_out_gyro_x,
   output logic signed [MOT_W-1:0]  rsp_out_gyro_y,
   output logic signed [MOT_W-1:0]  rsp_out_gyro_z,
   output logic signed [QUAT_W-1:0] rsp_out_quat_x,
   output logic signed [QUAT_W-1:0] rsp_out_quat_y,
   output logic signed [QUAT_W-1:0] rsp_out_quat_z,
   output logic signed [QUAT_W-1:0] rsp_out_quat_w,
   input  logic                     csr_wr_en,
   input  logic [GAP_W-1:0]         csr_wr_data
);

   isti_cmd_type  cmd;
   isti_stat_type stat;
   isti_rec_type  in_rec, rsp_rec;

   always_comb begin
      in_rec.time_us  = req_time_us;
      in_rec.accel[0] = req_accel_x;
      in_rec.accel[1] = req_accel_y;
      in_rec.accel[2] = req_accel_z;
      in_rec.gyro[0]  = req_gyro_x;
      in_rec.gyro[1]  = req_gyro_y;
      in_rec.gyro[2]  = req_gyro_z;
      in_rec.quat[0]  = req_quat_x;
      in_rec.quat[1]  = req_quat_y;
      in_rec.quat[2]  = req_quat_z;
      in_rec.quat[3]  = req_quat_w;
   end

   isti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   isti_dp #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_rec      (in_rec),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_rec     (rsp_rec)
   );

   assign rsp_out_time_us = rsp_rec.time_us;
   assign rsp_out_accel_x = rsp_rec.accel[0];
   assign rsp_out_accel_y = rsp_rec.accel[1];
   assign rsp_out_accel_z = rsp_rec.accel[2];
   assign rsp_out_gyro_x  = rsp_rec.gyro[0];
   assign rsp_out_gyro_y  = rsp_rec.gyro[1];
   assign rsp_out_gyro_z  = rsp_rec.gyro[2];
   assign rsp_out_quat_x  = rsp_rec.quat[0];
   assign rsp_out_quat_y  = rsp_rec.quat[1];
   assign rsp_out_quat_z  = rsp_rec.quat[2];
   assign rsp_out_quat_w  = rsp_rec.quat[3];

endmodule

### src/isti_div.sv
// ---------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle; the high part of the dividend is below the divisor.
// ---------------------------------------------------------------------------
module isti_div import isti_pkg::*; #(
   parameter int DVS_W = TIME_W,
   parameter int Q_W   = WBITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVS_W-1:0] num_hi,
   input  logic [Q_W-1:0]   num_lo,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [Q_W-1:0]   quot
);

   localparam int CNT_W = $clog2(Q_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [Q_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   always_comb begin
      trial = {rem_ff, lo_ff[Q_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = diff[DVS_W-1:0];
         lo_in  = {lo_ff[Q_W-2:0], 1'b1};
      end else begin
         rem_in = trial[DVS_W-1:0];
         lo_in  = {lo_ff[Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(Q_W);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num_hi;
         lo_ff  <= num_lo;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         lo_ff  <= lo_in;
      end
   end

   assign busy = busy_ff;
   assign quot = lo_ff;

endmodule

### src/isti_dp.sv
// ---------------------------------------------------------------------------
// IMU sample time interpolator datapath
// Sample memory, ring pointers, blend multiplier, square root and normaliser.
// ---------------------------------------------------------------------------
module isti_dp import isti_pkg::*; #(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  isti_cmd_type      cmd,
   output isti_stat_type     stat,
   input  logic              csr_wr_en,
   input  logic [GAP_W-1:0]  csr_wr_data,
   input  isti_rec_type      in_rec,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output isti_rec_type      rsp_rec
);

   localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(FIFO_DEPTH);

   isti_rec_type       sample_mem_ff [FIFO_DEPTH];
   isti_rec_type       rd_ff, rec0_ff, rec1_ff, rsp_rec_ff;
   logic [IDX_W-1:0]   head_ff, tail_slot, second_slot, rd_addr;
   logic [CNT_W-1:0]   count_ff;
   logic [GAP_W-1:0]   gap_ff;
   logic [TIME_W-1:0]  q_ff, t0, t1, q_m_t0, t1_m_q, t1_m_t0;
   logic               zero_w, full_w, need_div, wdiv_ff;
   logic [WBITS:0]     w_ff, wa;
   logic [3:0]         comp_ff;
   logic [1:0]         phase_ff, qidx;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;

   logic signed [MOT_W-1:0]  a_sel, b_sel;
   logic signed [32:0]       mul_a;
   logic signed [24:0]       mul_b;
   logic signed [57:0]       prod;
   logic signed [49:0]       mul_ff, acc_ff;
   logic signed [50:0]       sum_b, mot_r, mot_s, quat_r, quat_s;

   logic signed [24:0]       c_ff [4];
   logic signed [24:0]       cur_c;
   logic [MOT_W-1:0]         res_mot_ff [6];
   logic [QUAT_W-1:0]        res_quat_ff [4];

   logic [49:0]        x_ff, r_ff, bit_ff, trial;
   logic [24:0]        root, mag;
   logic [39:0]        nnum;
   logic               neg;

   logic               div_start, div_busy;
   logic [TIME_W-1:0]  div_hi, div_dvs;
   logic [WBITS-1:0]   div_lo, div_quot;

   function automatic logic [IDX_W-1:0] ring_slot(logic [IDX_W-1:0] h, logic [CNT_W-1:0] k);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(h) + (CNT_W + 1)'(k);
      if (s >= DEPTH_X) s = s - DEPTH_X;
      return s[IDX_W-1:0];
   endfunction

   function automatic logic signed [MOT_W-1:0] pick(isti_rec_type r, logic [3:0] k);
      logic signed [MOT_W-1:0] v;
      v = '0;
      case (k)
         4'd0:    v = $signed(r.accel[0]);
         4'd1:    v = $signed(r.accel[1]);
         4'd2:    v = $signed(r.accel[2]);
         4'd3:    v = $signed(r.gyro[0]);
         4'd4:    v = $signed(r.gyro[1]);
         4'd5:    v = $signed(r.gyro[2]);
         4'd6:    v = $signed({{(MOT_W-QUAT_W){r.quat[0][QUAT_W-1]}}, r.quat[0]});
         4'd7:    v = $signed({{(MOT_W-QUAT_W){r.quat[1][QUAT_W-1]}}, r.quat[1]});
         4'd8:    v = $signed({{(MOT_W-QUAT_W){r.quat[2][QUAT_W-1]}}, r.quat[2]});
         4'd9:    v = $signed({{(MOT_W-QUAT_W){r.quat[3][QUAT_W-1]}}, r.quat[3]});
         default: v = '0;
      endcase
      return v;
   endfunction

   // ring addressing
   always_comb begin
      tail_slot   = ring_slot(head_ff, count_ff);
      second_slot = ring_slot(head_ff, CNT_W'(1));
      rd_addr     = cmd.rd_second ? second_slot : head_ff;
   end

   // neighbour checks and weight selection
   always_comb begin
      t0       = rec0_ff.time_us;
      t1       = rec1_ff.time_us;
      q_m_t0   = q_ff - t0;
      t1_m_q   = t1 - q_ff;
      t1_m_t0  = t1 - t0;
      zero_w   = (t1 <= t0) || (q_ff <= t0);
      full_w   = !zero_w && (q_ff >= t1);
      need_div = !zero_w && !full_w;
      wa       = (WBITS + 1)'(1 << WBITS) - w_ff;
   end

   // shared multiplier operands
   always_comb begin
      qidx  = comp_ff[1:0] - 2'd2;
      a_sel = pick(rec0_ff, comp_ff);
      b_sel = pick(rec1_ff, comp_ff);
      cur_c = c_ff[comp_ff[1:0]];
      if (cmd.square) begin
         mul_a = {{8{cur_c[24]}}, cur_c};
         mul_b = cur_c;
      end else if (phase_ff == 2'd0) begin
         mul_a = {a_sel[MOT_W-1], a_sel};
         mul_b = $signed({8'b0, wa});
      end else begin
         mul_a = {b_sel[MOT_W-1], b_sel};
         mul_b = $signed({8'b0, w_ff});
      end
      prod   = mul_a * mul_b;
      sum_b  = $signed({acc_ff[49], acc_ff}) + $signed({mul_ff[49], mul_ff});
      mot_r  = sum_b + 51'sd32768;
      mot_s  = mot_r >>> WBITS;
      quat_r = sum_b + 51'sd128;
      quat_s = quat_r >>> 8;
   end

   // square root step and normaliser operands
   always_comb begin
      trial = r_ff + bit_ff;
      root  = r_ff[24:0];
      neg   = cur_c[24];
      mag   = neg ? 25'(-cur_c) : 25'(cur_c);
      nnum  = {1'b0, mag, 14'b0} + {16'b0, root[24:1]};
   end

   always_comb begin
      div_start = (cmd.weight && need_div) || cmd.norm_start;
      if (cmd.norm_start) begin
         div_hi  = {24'b0, nnum[39:16]};
         div_lo  = nnum[15:0];
         div_dvs = {23'b0, root};
      end else begin
         div_hi  = q_m_t0;
         div_lo  = '0;
         div_dvs = t1_m_t0;
      end
   end

   isti_div #(
      .DVS_W (TIME_W),
      .Q_W   (WBITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num_hi  (div_hi),
      .num_lo  (div_lo),
      .divisor (div_dvs),
      .busy    (div_busy),
      .quot    (div_quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.push) sample_mem_ff[tail_slot] <= in_rec;
      if (cmd.rd_front || cmd.rd_second) rd_ff <= sample_mem_ff[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         gap_ff       <= GAP_RESET;
         rsp_valid_ff <= 1'b0;
         comp_ff      <= '0;
         phase_ff     <= '0;
      end else begin
         if (csr_wr_en) gap_ff <= csr_wr_data;
         if (cmd.push) begin
            if (count_ff == CNT_FULL) head_ff <= second_slot;
            else                      count_ff <= count_ff + 1'b1;
         end else if (cmd.drop) begin
            head_ff  <= second_slot;
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.result)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.query_load) begin
            comp_ff  <= '0;
            phase_ff <= '0;
         end else if (cmd.blend) begin
            if (phase_ff == 2'd2) begin
               phase_ff <= '0;
               comp_ff  <= stat.blend_last ? 4'd0 : comp_ff + 1'b1;
            end else begin
               phase_ff <= phase_ff + 1'b1;
            end
         end else if (cmd.square) begin
            if (phase_ff == 2'd1) begin
               phase_ff <= '0;
               comp_ff  <= stat.square_last ? 4'd0 : comp_ff + 1'b1;
            end else begin
               phase_ff <= phase_ff + 1'b1;
            end
         end else if (cmd.norm_store) begin
            comp_ff <= stat.norm_last ? 4'd0 : comp_ff + 1'b1;
         end
      end
   end

   // arithmetic payload
   always_ff @(posedge clock) begin
      if (cmd.query_load) begin
         q_ff   <= in_rec.time_us;
         x_ff   <= '0;
         r_ff   <= '0;
         bit_ff <= 50'(1) << 48;
         for (int i = 0; i < 4; i++) res_quat_ff[i] <= '0;
      end
      if (cmd.cap_front)  rec0_ff <= rd_ff;
      if (cmd.cap_second) rec1_ff <= rd_ff;
      if (cmd.weight) begin
         wdiv_ff <= need_div;
         w_ff    <= full_w ? (WBITS + 1)'(1 << WBITS) : '0;
      end
      if (cmd.weight_store && wdiv_ff) w_ff <= {1'b0, div_quot};
      if (cmd.blend) begin
         case (phase_ff)
            2'd0: mul_ff <= prod[49:0];
            2'd1: begin
               acc_ff <= mul_ff;
               mul_ff <= prod[49:0];
            end
            default: begin
               if (comp_ff < 4'd6) res_mot_ff[comp_ff[2:0]] <= mot_s[MOT_W-1:0];
               else                c_ff[qidx] <= quat_s[24:0];
            end
         endcase
      end
      if (cmd.square) begin
         if (phase_ff == 2'd0) mul_ff <= prod[49:0];
         else                  x_ff   <= x_ff + $unsigned(mul_ff);
      end
      if (cmd.sqrt) begin
         if (x_ff >= trial) begin
            x_ff <= x_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.norm_store) begin
         res_quat_ff[comp_ff[1:0]] <= neg ? (16'd0 - div_quot) : div_quot;
      end
      if (cmd.result) begin
         rsp_status_ff      <= cmd.status;
         rsp_rec_ff.time_us <= q_ff;
         for (int i = 0; i < 3; i++) begin
            rsp_rec_ff.accel[i] <= (cmd.status == STATUS_OK) ? res_mot_ff[i] : '0;
            rsp_rec_ff.gyro[i]  <= (cmd.status == STATUS_OK) ? res_mot_ff[i+3] : '0;
         end
         for (int i = 0; i < 4; i++) begin
            rsp_rec_ff.quat[i] <= (cmd.status == STATUS_OK) ? res_quat_ff[i] : '0;
         end
      end
   end

   always_comb begin
      stat.few         = count_ff < CNT_W'(2);
      stat.early       = t0 > q_ff;
      stat.later       = t1 < q_ff;
      stat.gap         = (q_m_t0 > TIME_W'(gap_ff)) || (t1_m_q > TIME_W'(gap_ff));
      stat.div_busy    = div_busy;
      stat.blend_last  = (comp_ff == 4'd9) && (phase_ff == 2'd2);
      stat.square_last = (comp_ff == 4'd3) && (phase_ff == 2'd1);
      stat.sqrt_last   = bit_ff[0];
      stat.norm_zero   = (r_ff == '0);
      stat.norm_last   = (comp_ff[1:0] == 2'd3);
      stat.out_busy    = rsp_valid_ff;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_rec    = rsp_rec_ff;

endmodule

### src/isti_ctrl.sv
// ---------------------------------------------------------------------------
// IMU sample time interpolator controller
// Sequences push, prune loop, weight division, blend, root and normalising.
// ---------------------------------------------------------------------------
module isti_ctrl import isti_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_mode,
   output logic          req_ready,
   input  isti_stat_type stat,
   output isti_cmd_type  cmd
);

   isti_state_type state_ff, state_in;
   logic [1:0]     status_ff, status_in;
   logic           final_ff, final_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= STATUS_OK;
         final_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         final_ff  <= final_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      final_in   = final_ff;
      cmd        = '0;
      cmd.status = status_ff;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_QUERY) begin
                  cmd.query_load = 1'b1;
                  status_in      = STATUS_OK;
                  final_in       = 1'b0;
                  state_in       = ST_CHECK;
               end else begin
                  cmd.push = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (stat.few) begin
               status_in = STATUS_FEW;
               state_in  = ST_OUT;
            end else begin
               cmd.rd_front = 1'b1;
               state_in     = ST_RD0;
            end
         end
         ST_RD0: begin
            cmd.cap_front = 1'b1;
            cmd.rd_second = 1'b1;
            state_in      = ST_RD1;
         end
         ST_RD1: begin
            cmd.cap_second = 1'b1;
            state_in       = ST_CMP;
         end
         ST_CMP: begin
            if (final_ff) begin
               state_in = ST_WEIGHT;
            end else if (stat.early) begin
               status_in = STATUS_EARLY;
               state_in  = ST_OUT;
            end else if (stat.later) begin
               cmd.drop = 1'b1;
               state_in = ST_CHECK;
            end else if (stat.gap) begin
               // drop the front once, then use whatever pair is left
               cmd.drop = 1'b1;
               final_in = 1'b1;
               state_in = ST_CHECK;
            end else begin
               state_in = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            cmd.weight = 1'b1;
            state_in   = ST_WDIV;
         end
         ST_WDIV: begin
            if (!stat.div_busy) begin
               cmd.weight_store = 1'b1;
               state_in         = ST_BLEND;
            end
         end
         ST_BLEND: begin
            cmd.blend = 1'b1;
            if (stat.blend_last) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            if (stat.square_last) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt = 1'b1;
            if (stat.sqrt_last) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (stat.norm_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.norm_start = 1'b1;
               state_in       = ST_NWAIT;
            end
         end
         ST_NWAIT: begin
            if (!stat.div_busy) begin
               cmd.norm_store = 1'b1;
               state_in       = stat.norm_last ? ST_OUT : ST_NORM;
            end
         end
         ST_OUT: begin
            // hold until the previous result transaction has gone
            if (!stat.out_busy) begin
               cmd.result = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### src/isti_checker.sv
// ---------------------------------------------------------------------------
// IMU sample time interpolator port checker
// Watches the top-level ports; bound to the top level below.
// ---------------------------------------------------------------------------
`include "imu_sample_time_interpolator_defines.svh"

module isti_checker import isti_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_mode,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [1:0]               rsp_status,
   input logic [TIME_W-1:0]        rsp_out_time_us,
   input logic signed [MOT_W-1:0]  rsp_out_accel_x,
   input logic signed [MOT_W-1:0]  rsp_out_accel_y,
   input logic signed [MOT_W-1:0]  rsp_out_accel_z,
   input logic signed [MOT_W-1:0]  rsp_out_gyro_x,
   input logic signed [MOT_W-1:0]  rsp_out_gyro_y,
   input logic signed [MOT_W-1:0]  rsp_out_gyro_z,
   input logic signed [QUAT_W-1:0] rsp_out_quat_x,
   input logic signed [QUAT_W-1:0] rsp_out_quat_y,
   input logic signed [QUAT_W-1:0] rsp_out_quat_z,
   input logic signed [QUAT_W-1:0] rsp_out_quat_w
);

   `ISTI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_out_time_us))

   `ISTI_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK),
      rsp_out_accel_x == 0 && rsp_out_accel_y == 0 && rsp_out_accel_z == 0 &&
      rsp_out_gyro_x == 0 && rsp_out_gyro_y == 0 && rsp_out_gyro_z == 0 &&
      rsp_out_quat_x == 0 && rsp_out_quat_y == 0 && rsp_out_quat_z == 0 &&
      rsp_out_quat_w == 0)

   `ISTI_ASSERT_NEXT(a_push_silent, clock, reset,
      req_valid && req_ready && (req_mode == MODE_PUSH) && !rsp_valid, !rsp_valid)

   `ISTI_ASSERT_NEXT(a_query_busy, clock, reset,
      req_valid && req_ready && (req_mode == MODE_QUERY), !req_ready)

endmodule

bind imu_sample_time_interpolator isti_checker u_checker (.*);
